### hdl/vfm_pkg.sv
// Shared types, request codes and face tables for the voxel face mesher.
package vfm_pkg;

    localparam int CHUNK_EDGE_DEF = 16;

    localparam logic [1:0] REQ_WRITE  = 2'd0;
    localparam logic [1:0] REQ_MESH   = 2'd1;
    localparam logic [1:0] REQ_REPORT = 2'd2;

    localparam logic [2:0] FACE_LAST   = 3'd5;
    localparam logic [2:0] CORNER_LAST = 3'd5;
    localparam logic [2:0] RD_LAST     = 3'd6;

    // corner offsets per face, dx<<2 | dy<<1 | dz, in triangle order
    localparam logic [2:0] FACE_CORNERS [0:5][0:5] = '{
        '{3'd3, 3'd2, 3'd0, 3'd0, 3'd1, 3'd3},
        '{3'd7, 3'd5, 3'd4, 3'd4, 3'd6, 3'd7},
        '{3'd0, 3'd4, 3'd5, 3'd5, 3'd1, 3'd0},
        '{3'd2, 3'd3, 3'd7, 3'd7, 3'd6, 3'd2},
        '{3'd0, 3'd2, 3'd6, 3'd6, 3'd4, 3'd0},
        '{3'd1, 3'd5, 3'd7, 3'd7, 3'd3, 3'd1}
    };

    localparam logic [3:0] FACE_CODE [0:5] = '{4'h9, 4'h1, 4'hA, 4'h2, 4'hC, 4'h4};

    typedef struct packed {
        logic [1:0] req_type;
        logic [3:0] pos_x;
        logic [3:0] pos_y;
        logic [3:0] pos_z;
        logic [7:0] voxel_type;
    } t_req;

    typedef struct packed {
        logic        vertex_valid;
        logic [14:0] vertex_word;
        logic [11:0] attr_word;
        logic [17:0] vertex_index;
        logic        last;
    } t_res;

    typedef struct packed {
        logic       load;
        logic       clr;
        logic       wr;
        logic       rd_en;
        logic [2:0] rd_idx;   // 0 center, 1..6 neighbor faces
        logic       emit;
        logic [2:0] face;
        logic [2:0] corner;
        logic       last;
        logic       report;
    } t_cmd;

    typedef struct packed {
        logic       clr_done;
        logic       type_nz;
        logic [5:0] mask;     // one bit per exposed face
    } t_sts;

endpackage

### hdl/vfm_datapath.sv
// Datapath: voxel memory, request register, neighbor lookup, vertex counter, result register.
module vfm_datapath #(
    parameter int CHUNK_EDGE = vfm_pkg::CHUNK_EDGE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  vfm_pkg::t_req i_req,
    input  vfm_pkg::t_cmd i_cmd,
    output vfm_pkg::t_sts o_sts,
    output logic          o_strobe,
    output vfm_pkg::t_res o_res
);

    localparam int VOX = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
    localparam int AW  = $clog2(VOX);
    localparam logic [4:0]    EDGE5    = 5'(CHUNK_EDGE);
    localparam logic [AW-1:0] CLR_LAST = AW'(VOX - 1);

    logic [7:0] r_mem [0:VOX-1];

    vfm_pkg::t_req r_req;
    logic [AW-1:0] r_clr_addr;
    logic [7:0]    r_rd;
    logic          r_rd_in;
    logic          r_rd_v;
    logic [2:0]    r_rd_idx;
    logic [7:0]    r_type;
    logic [5:0]    r_mask;
    logic [17:0]   r_cnt;
    logic          r_strobe;
    vfm_pkg::t_res r_res;

    logic [4:0]    cx, cy, cz;
    logic [4:0]    nx, ny, nz;
    logic [31:0]   lin;
    logic [AW-1:0] raddr;
    logic          rin;
    logic [7:0]    rd_val;
    logic [2:0]    corner;
    logic [4:0]    vx, vy, vz;

    assign cx = {1'b0, r_req.pos_x};
    assign cy = {1'b0, r_req.pos_y};
    assign cz = {1'b0, r_req.pos_z};

    // neighbor coordinate; -1 wraps to 31, which is never inside
    always_comb begin
        nx = cx;
        ny = cy;
        nz = cz;
        unique case (i_cmd.rd_idx)
            3'd1:    nx = cx - 5'd1;
            3'd2:    nx = cx + 5'd1;
            3'd3:    ny = cy - 5'd1;
            3'd4:    ny = cy + 5'd1;
            3'd5:    nz = cz - 5'd1;
            3'd6:    nz = cz + 5'd1;
            default: nx = cx;
        endcase
    end

    assign lin   = 32'(nx) + 32'(CHUNK_EDGE) * (32'(ny) + 32'(CHUNK_EDGE) * 32'(nz));
    assign raddr = rin ? lin[AW-1:0] : '0;
    assign rin   = (nx < EDGE5) && (ny < EDGE5) && (nz < EDGE5);

    assign rd_val = r_rd_in ? r_rd : 8'd0;

    // memory: clearing pass or voxel write, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_mem[r_clr_addr] <= 8'd0;
        end else if (i_cmd.wr && rin) begin
            r_mem[raddr] <= r_req.voxel_type;
        end
        if (i_cmd.rd_en && rin) begin
            r_rd <= r_mem[raddr];
        end
        r_rd_in  <= rin;
        r_rd_idx <= i_cmd.rd_idx;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (r_rd_v) begin
            if (r_rd_idx == 3'd0) begin
                r_type <= rd_val;
            end else begin
                r_mask[r_rd_idx - 3'd1] <= (rd_val == 8'd0);
            end
        end
    end

    assign corner = vfm_pkg::FACE_CORNERS[i_cmd.face][i_cmd.corner];
    assign vx = cx + {4'd0, corner[2]};
    assign vy = cy + {4'd0, corner[1]};
    assign vz = cz + {4'd0, corner[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_rd_v     <= 1'b0;
            r_cnt      <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_rd_v   <= i_cmd.rd_en;
            r_strobe <= i_cmd.emit || i_cmd.report;
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (i_cmd.report) begin
                r_cnt <= '0;
            end else if (i_cmd.emit && (r_cnt != '1)) begin
                r_cnt <= r_cnt + 18'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_res.vertex_valid <= 1'b1;
            r_res.vertex_word  <= {vx, vy, vz};
            r_res.attr_word    <= {r_type, vfm_pkg::FACE_CODE[i_cmd.face]};
            r_res.vertex_index <= r_cnt;
            r_res.last         <= i_cmd.last;
        end else if (i_cmd.report) begin
            r_res.vertex_valid <= 1'b0;
            r_res.vertex_word  <= '0;
            r_res.attr_word    <= '0;
            r_res.vertex_index <= r_cnt;
            r_res.last         <= 1'b1;
        end
    end

    assign o_sts.clr_done = (r_clr_addr == CLR_LAST);
    assign o_sts.type_nz  = (r_type != 8'd0);
    assign o_sts.mask     = r_mask;
    assign o_strobe       = r_strobe;
    assign o_res          = r_res;

endmodule

### hdl/vfm_ctrl.sv
// Controller: sequences clearing, writes, neighbor reads, face emission and reports.
module vfm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_req_type,
    input  vfm_pkg::t_sts i_sts,
    output vfm_pkg::t_cmd o_cmd,
    output logic          o_busy
);

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_WR, S_RD, S_WT, S_DEC, S_EMIT, S_RPT
    } t_state;

    t_state     r_state;
    logic [2:0] r_idx;
    logic [2:0] r_face;
    logic [2:0] r_corner;

    logic [2:0] first_face;
    logic [2:0] next_face;
    logic       more;

    // lowest exposed face, and next exposed face above the current one
    always_comb begin
        first_face = 3'd0;
        next_face  = 3'd0;
        more       = 1'b0;
        for (int i = 5; i >= 0; i--) begin
            if (i_sts.mask[i]) begin
                first_face = 3'(i);
            end
            if (i_sts.mask[i] && (3'(i) > r_face)) begin
                next_face = 3'(i);
                more      = 1'b1;
            end
        end
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == S_IDLE) && i_start;
        o_cmd.clr    = (r_state == S_CLR);
        o_cmd.wr     = (r_state == S_WR);
        o_cmd.rd_en  = (r_state == S_RD);
        o_cmd.rd_idx = (r_state == S_RD) ? r_idx : 3'd0;
        o_cmd.emit   = (r_state == S_EMIT);
        o_cmd.face   = r_face;
        o_cmd.corner = r_corner;
        o_cmd.last   = (r_corner == vfm_pkg::CORNER_LAST) && !more;
        o_cmd.report = (r_state == S_RPT);
    end

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_idx    <= 3'd0;
            r_face   <= 3'd0;
            r_corner <= 3'd0;
        end else begin
            unique case (r_state)
                S_CLR: begin
                    if (i_sts.clr_done) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_idx <= 3'd0;
                    if (i_start) begin
                        unique case (i_req_type)
                            vfm_pkg::REQ_WRITE:  r_state <= S_WR;
                            vfm_pkg::REQ_MESH:   r_state <= S_RD;
                            vfm_pkg::REQ_REPORT: r_state <= S_RPT;
                            default:             r_state <= S_IDLE;
                        endcase
                    end
                end
                S_WR:  r_state <= S_IDLE;
                S_RPT: r_state <= S_IDLE;
                S_RD: begin
                    r_idx <= r_idx + 3'd1;
                    if (r_idx == vfm_pkg::RD_LAST) begin
                        r_state <= S_WT;
                    end
                end
                S_WT:  r_state <= S_DEC;
                S_DEC: begin
                    r_face   <= first_face;
                    r_corner <= 3'd0;
                    if (!i_sts.type_nz || (i_sts.mask == 6'd0)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (r_corner == vfm_pkg::CORNER_LAST) begin
                        r_corner <= 3'd0;
                        if (more) begin
                            r_face <= next_face;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_corner <= r_corner + 3'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### hdl/voxel_face_mesher_top.sv
// Write request: no result. Report request: the report state's result is registered.
// Mesh request: 7 memory reads (center, six neighbors) then one vertex per cycle;
// busy through the reads, the wait and decode states and each exposed face's vertices;
// a new request is taken in a cycle in which busy is low.
// Reset: the voxel memory is swept to zero, one entry a cycle, all CHUNK_EDGE^3 entries
// (4096 at the default) with busy high. Results last one cycle; the receiver cannot stall.
module voxel_face_mesher_top #(
    parameter int CHUNK_EDGE = vfm_pkg::CHUNK_EDGE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  vfm_pkg::t_req i_req,
    output logic          busy,
    output logic          o_strobe,
    output vfm_pkg::t_res o_res
);

    vfm_pkg::t_cmd cmd;
    vfm_pkg::t_sts sts;

    vfm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req.req_type),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    vfm_datapath #(
        .CHUNK_EDGE (CHUNK_EDGE)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    // no request yields a result in the cycle right after it is taken
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_strobe)
        else $error("result one cycle after request accept");

    // a report is always a single, final result
    a_report_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_res.vertex_valid) |-> o_res.last)
        else $error("report result without last");

    // vertices of one request come back to back
    a_vertex_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_res.vertex_valid && !o_res.last) |=> (o_strobe && o_res.vertex_valid))
        else $error("gap inside vertex burst");

endmodule

### dv/voxel_face_mesher_checker.sv
// Request monitor, face-culling predictor and result comparator for the voxel face mesher.
`timescale 1ns / 1ps
module voxel_face_mesher_checker #(
    parameter int EDGE = vfm_pkg::CHUNK_EDGE_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  vfm_pkg::t_req i_req,
    input  logic          i_strobe,
    input  vfm_pkg::t_res i_res,
    output logic          o_taken,
    output int            o_pending,
    output int            o_errors
);

    localparam int          NUM_VOXELS = EDGE * EDGE * EDGE;
    localparam logic [17:0] COUNT_SAT  = 18'h3FFFF;
    localparam int          MAX_SHOWN  = 10;

    // faces in test order: -X, +X, -Y, +Y, -Z, +Z
    // corners are dx<<2 | dy<<1 | dz, two triangles per face
    localparam logic [2:0] CORNERS [0:5][0:5] = '{
        '{3'd3, 3'd2, 3'd0, 3'd0, 3'd1, 3'd3},
        '{3'd7, 3'd5, 3'd4, 3'd4, 3'd6, 3'd7},
        '{3'd0, 3'd4, 3'd5, 3'd5, 3'd1, 3'd0},
        '{3'd2, 3'd3, 3'd7, 3'd7, 3'd6, 3'd2},
        '{3'd0, 3'd2, 3'd6, 3'd6, 3'd4, 3'd0},
        '{3'd1, 3'd5, 3'd7, 3'd7, 3'd3, 3'd1}
    };
    localparam logic [3:0] DIR_CODE [0:5] = '{4'h9, 4'h1, 4'hA, 4'h2, 4'hC, 4'h4};
    localparam int STEP_X [0:5] = '{-1, 1, 0, 0, 0, 0};
    localparam int STEP_Y [0:5] = '{0, 0, -1, 1, 0, 0};
    localparam int STEP_Z [0:5] = '{0, 0, 0, 0, -1, 1};

    logic [7:0]    voxels [0:NUM_VOXELS-1];
    logic [17:0]   vertex_count;
    vfm_pkg::t_res vertex_q [$];
    vfm_pkg::t_res want;

    // outside the chunk reads as empty
    function automatic logic [7:0] occupant(int x, int y, int z);
        if (x < 0 || x >= EDGE || y < 0 || y >= EDGE || z < 0 || z >= EDGE)
            return 8'd0;
        return voxels[x + EDGE * (y + EDGE * z)];
    endfunction

    task automatic apply_request(vfm_pkg::t_req r);
        vfm_pkg::t_res v;
        logic [7:0]    kind;
        logic [5:0]    exposed;
        logic [2:0]    c;
        int            x, y, z, f, k, final_face;
        x = int'(r.pos_x);
        y = int'(r.pos_y);
        z = int'(r.pos_z);
        case (r.req_type)
            vfm_pkg::REQ_WRITE: begin
                if (x < EDGE && y < EDGE && z < EDGE)
                    voxels[x + EDGE * (y + EDGE * z)] = r.voxel_type;
            end
            vfm_pkg::REQ_REPORT: begin
                v = '0;
                v.vertex_index = vertex_count;
                v.last = 1'b1;
                vertex_q.push_back(v);
                vertex_count = '0;
            end
            vfm_pkg::REQ_MESH: begin
                kind = occupant(x, y, z);
                exposed = '0;
                final_face = -1;
                if (kind != 8'd0) begin
                    for (f = 0; f < 6; f++) begin
                        if (occupant(x + STEP_X[f], y + STEP_Y[f], z + STEP_Z[f]) == 8'd0) begin
                            exposed[f] = 1'b1;
                            final_face = f;
                        end
                    end
                end
                for (f = 0; f < 6; f++) begin
                    if (exposed[f]) begin
                        for (k = 0; k < 6; k++) begin
                            c = CORNERS[f][k];
                            v.vertex_valid = 1'b1;
                            v.vertex_word  = {5'(x + int'(c[2])), 5'(y + int'(c[1])),
                                              5'(z + int'(c[0]))};
                            v.attr_word    = {kind, 4'h0} + 12'(DIR_CODE[f]);
                            v.vertex_index = vertex_count;
                            v.last         = (f == final_face) && (k == 5);
                            vertex_q.push_back(v);
                            if (vertex_count != COUNT_SAT)
                                vertex_count = vertex_count + 18'd1;
                        end
                    end
                end
            end
            default: ;  // unused code: no effect
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_VOXELS; i++)
                voxels[i] = 8'd0;
            vertex_count = '0;
            vertex_q.delete();
            o_errors = 0;
            o_taken <= 1'b0;
        end else begin
            // retire the oldest expectation before adding new ones
            if (i_strobe) begin
                if (vertex_q.size() == 0) begin
                    o_errors = o_errors + 1;
                    if (o_errors <= MAX_SHOWN)
                        $display("unexpected result: valid %0d word %h attr %h index %0d last %0d",
                                 i_res.vertex_valid, i_res.vertex_word, i_res.attr_word,
                                 i_res.vertex_index, i_res.last);
                end else begin
                    want = vertex_q.pop_front();
                    if (want.vertex_valid !== i_res.vertex_valid ||
                        want.vertex_word  !== i_res.vertex_word  ||
                        want.attr_word    !== i_res.attr_word    ||
                        want.vertex_index !== i_res.vertex_index ||
                        want.last         !== i_res.last) begin
                        o_errors = o_errors + 1;
                        if (o_errors <= MAX_SHOWN)
                            $display("mismatch: exp v%0d w%h a%h i%0d l%0d, got v%0d w%h a%h i%0d l%0d",
                                     want.vertex_valid, want.vertex_word, want.attr_word,
                                     want.vertex_index, want.last,
                                     i_res.vertex_valid, i_res.vertex_word, i_res.attr_word,
                                     i_res.vertex_index, i_res.last);
                    end
                end
            end
            if (i_start && !i_busy)
                apply_request(i_req);
            o_taken <= i_start && !i_busy;
        end
        o_pending = vertex_q.size();
    end

endmodule

### dv/voxel_face_mesher_top_test.sv
// Stimulus and verdict for the voxel face mesher: directed faces and random traffic.
`timescale 1ns / 1ps
module voxel_face_mesher_top_test;

    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT  = 1_500_000;
    localparam int         RANDOM_ITEMS = 350;
    localparam int         TAIL_ITEMS   = 60;
    localparam int         SETTLE       = 60;

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    logic          o_strobe;
    vfm_pkg::t_req i_req;
    vfm_pkg::t_res o_res;
    logic          req_taken;
    int            pending;
    int            errors;
    int            cycles = 0;
    bit            gaps_on;

    voxel_face_mesher_top uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    voxel_face_mesher_checker mesh_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_busy    (busy),
        .i_req     (i_req),
        .i_strobe  (o_strobe),
        .i_res     (o_res),
        .o_taken   (req_taken),
        .o_pending (pending),
        .o_errors  (errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("** voxel_face_mesher_top: FAILED **");
            $finish;
        end
    end

    // called at a falling edge; returns at a falling edge after the request is taken
    task automatic issue(logic [1:0] kind, int x, int y, int z, int vt);
        vfm_pkg::t_req r;
        r.req_type   = kind;
        r.pos_x      = 4'(x);
        r.pos_y      = 4'(y);
        r.pos_z      = 4'(z);
        r.voxel_type = 8'(vt);
        start <= 1'b1;
        i_req <= r;
        do @(negedge i_clk); while (!req_taken);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    // zone 0: dense 4x4x4 block, 1: near the chunk faces, else anywhere
    function automatic int pick_coord(int zone);
        if (zone == 0)
            return $urandom_range(4, 7);
        if (zone == 1)
            return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1) : $urandom_range(14, 15);
        return $urandom_range(0, 15);
    endfunction

    task automatic random_request();
        int         sel, zone, vt;
        logic [1:0] kind;
        sel  = $urandom_range(0, 99);
        zone = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 2);
        vt   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 255);
        if (sel < 38)
            kind = vfm_pkg::REQ_WRITE;
        else if (sel < 84)
            kind = vfm_pkg::REQ_MESH;
        else if (sel < 94)
            kind = vfm_pkg::REQ_REPORT;
        else
            kind = REQ_UNUSED;
        issue(kind, pick_coord(zone), pick_coord(zone), pick_coord(zone), vt);
    endtask

    initial begin
        int i;
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        gaps_on = 1'b1;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        issue(vfm_pkg::REQ_REPORT, 0, 0, 0, 0);
        // both chunk corners: every face exposed, three of them on the boundary
        issue(vfm_pkg::REQ_WRITE, 0, 0, 0, 8'hFF);
        issue(vfm_pkg::REQ_MESH, 0, 0, 0, 0);
        issue(vfm_pkg::REQ_WRITE, 15, 15, 15, 8'h01);
        issue(vfm_pkg::REQ_MESH, 15, 15, 15, 8'hFF);
        issue(vfm_pkg::REQ_MESH, 8, 3, 11, 0);   // empty voxel
        issue(REQ_UNUSED, 0, 0, 0, 8'h5A);       // must not overwrite
        issue(vfm_pkg::REQ_MESH, 0, 0, 0, 0);
        // fully enclosed voxel, then one face opened
        issue(vfm_pkg::REQ_WRITE, 7, 7, 7, 8'hAA);
        issue(vfm_pkg::REQ_WRITE, 6, 7, 7, 8'h01);
        issue(vfm_pkg::REQ_WRITE, 8, 7, 7, 8'h80);
        issue(vfm_pkg::REQ_WRITE, 7, 6, 7, 8'h7F);
        issue(vfm_pkg::REQ_WRITE, 7, 8, 7, 8'h55);
        issue(vfm_pkg::REQ_WRITE, 7, 7, 6, 8'hFE);
        issue(vfm_pkg::REQ_WRITE, 7, 7, 8, 8'h33);
        issue(vfm_pkg::REQ_MESH, 7, 7, 7, 0);
        issue(vfm_pkg::REQ_WRITE, 7, 7, 8, 0);
        issue(vfm_pkg::REQ_MESH, 7, 7, 7, 0);
        issue(vfm_pkg::REQ_MESH, 8, 7, 7, 0);
        issue(vfm_pkg::REQ_REPORT, 0, 0, 0, 0);
        issue(vfm_pkg::REQ_WRITE, 0, 0, 0, 0);
        issue(vfm_pkg::REQ_MESH, 0, 0, 0, 0);
        issue(vfm_pkg::REQ_REPORT, 15, 15, 15, 8'hFF);
        drain();

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2)
                drain();
            if (i == RANDOM_ITEMS - TAIL_ITEMS)
                gaps_on = 1'b0;
            random_request();
        end

        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (SETTLE) @(negedge i_clk);
        if (errors == 0 && pending == 0)
            $display("** voxel_face_mesher_top: PASSED **");
        else
            $display("** voxel_face_mesher_top: FAILED **");
        $finish;
    end

endmodule
